// ----- rtl/vector_regfile_fragment_mapper_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the vector register file fragment mapper.
// Each macro checks one implication on the rising clock, off during reset.
// ----------------------------------------------------------------------------
`ifndef VECTOR_REGFILE_FRAGMENT_MAPPER_MACROS_SVH
`define VECTOR_REGFILE_FRAGMENT_MAPPER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define VRFM_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define VRFM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/vrfm_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vrfm_pkg
// Types, codes and limits shared by the fragment mapper modules.
// ----------------------------------------------------------------------------
package vrfm_pkg;

    // Request limits and geometry bounds.
    localparam int MAX_RANGE_BYTES = 64;
    localparam int MAX_WORD_BYTES  = 64;
    localparam int NUM_ARCH_REGS   = 32;
    localparam int MAX_VLEN_BYTES  = 8192;
    localparam int MAX_LANES       = 64;
    localparam int MAX_BANKS       = 64;

    // Field widths.
    localparam int VLEN_W = 14;
    localparam int GEO_W  = 7;
    localparam int BE_W   = 64;
    localparam int BASE_W = 19;
    localparam int DIV_W  = 20;
    localparam int DIVR_W = 14;

    // Configuration register indexes.
    localparam logic [1:0] CFG_VLEN  = 2'd0;
    localparam logic [1:0] CFG_LWB   = 2'd1;
    localparam logic [1:0] CFG_LANES = 2'd2;
    localparam logic [1:0] CFG_BANKS = 2'd3;

    // Reset values of the configuration registers.
    localparam logic [VLEN_W-1:0] CFG_RST_VLEN  = 14'd64;
    localparam logic [GEO_W-1:0]  CFG_RST_LWB   = 7'd8;
    localparam logic [GEO_W-1:0]  CFG_RST_LANES = 7'd4;
    localparam logic [GEO_W-1:0]  CFG_RST_BANKS = 7'd2;

    // Result status codes.
    localparam logic [2:0] ST_OK   = 3'd0;
    localparam logic [2:0] ST_GEO  = 3'd1;
    localparam logic [2:0] ST_GRP  = 3'd2;
    localparam logic [2:0] ST_SIZE = 3'd3;
    localparam logic [2:0] ST_CAP  = 3'd4;

    typedef struct packed {
        logic [4:0]      first_reg;
        logic [5:0]      reg_count;
        logic [15:0]     range_offset;
        logic [6:0]      range_size;
        logic [BE_W-1:0] byte_mask;
    } t_req;

    typedef struct packed {
        logic [5:0]      lane_id;
        logic [5:0]      bank_id;
        logic [15:0]     row_index;
        logic [5:0]      offset_in_word;
        logic [15:0]     fragment_offset;
        logic [6:0]      fragment_size;
        logic [BE_W-1:0] word_enable;
        logic            last_fragment;
        logic [2:0]      status;
    } t_rsp;

    typedef struct packed {
        logic [VLEN_W-1:0] vlen_bytes;
        logic [GEO_W-1:0]  lane_word_bytes;
        logic [GEO_W-1:0]  num_lanes;
        logic [GEO_W-1:0]  banks_per_lane;
        logic [VLEN_W-1:0] lane_stride;
        logic              geo_ok;
    } t_cfg;

    typedef struct packed {
        logic              start;
        logic [DIV_W-1:0]  dividend;
        logic [DIVR_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic              busy;
        logic              done;
        logic [DIV_W-1:0]  quot;
        logic [DIVR_W-1:0] rem;
    } t_div_rsp;

endpackage

// ----- rtl/vrfm_chan_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vrfm_chan_if
// Valid/ready channel carrying one payload item per transfer.
// ----------------------------------------------------------------------------
interface vrfm_chan_if #(
    parameter type t_payload = logic
) ();
    logic     valid;
    logic     ready;
    t_payload data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/vector_regfile_fragment_mapper.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vector_regfile_fragment_mapper
// Splits a byte range of a vector register group into lane-word fragments.
// ----------------------------------------------------------------------------
//  Channel  Dir  Payload   Transfer
//  i_req    in   t_req     i_req.valid & i_req.ready
//  o_rsp    out  t_rsp     o_rsp.valid & o_rsp.ready
//  cfg      in   14 bits   i_cfg_we
//
// After a transfer, the shared divider runs the geometry check and then the word,
// lane and bank divisions in turn; the fragments then enter the output register
// one by one. Geometry outside the limits is reported straight from the check
// state, other errors once the geometry division has finished. Reset is
// synchronous and returns the registers to 64, 8, 4 and 2.
// A stalled o_rsp holds the sequencer in its emit and error states; a new request
// is taken as soon as the last result has entered the output register.
// ----------------------------------------------------------------------------
`include "vector_regfile_fragment_mapper_macros.svh"

module vector_regfile_fragment_mapper (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [1:0]                     i_cfg_idx,
    input  logic [vrfm_pkg::VLEN_W-1:0]    i_cfg_data,
    vrfm_chan_if.sink                      i_req,
    vrfm_chan_if.source                    o_rsp
);
    logic [vrfm_pkg::VLEN_W-1:0] r_vlen;
    logic [vrfm_pkg::GEO_W-1:0]  r_lwb;
    logic [vrfm_pkg::GEO_W-1:0]  r_lanes;
    logic [vrfm_pkg::GEO_W-1:0]  r_banks;
    logic [vrfm_pkg::VLEN_W-1:0] r_stride;

    vrfm_pkg::t_cfg     w_cfg;
    vrfm_pkg::t_div_req w_div_req;
    vrfm_pkg::t_div_rsp w_div_rsp;
    vrfm_pkg::t_rsp     w_rsp;
    logic               w_rsp_valid;
    logic               w_req_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vlen  <= vrfm_pkg::CFG_RST_VLEN;
            r_lwb   <= vrfm_pkg::CFG_RST_LWB;
            r_lanes <= vrfm_pkg::CFG_RST_LANES;
            r_banks <= vrfm_pkg::CFG_RST_BANKS;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                vrfm_pkg::CFG_VLEN:  r_vlen  <= i_cfg_data;
                vrfm_pkg::CFG_LWB:   r_lwb   <= i_cfg_data[vrfm_pkg::GEO_W-1:0];
                vrfm_pkg::CFG_LANES: r_lanes <= i_cfg_data[vrfm_pkg::GEO_W-1:0];
                vrfm_pkg::CFG_BANKS: r_banks <= i_cfg_data[vrfm_pkg::GEO_W-1:0];
            endcase
        end
    end

    // Bytes covered by one word across all lanes; the register length must be
    // a whole number of these.
    always_ff @(posedge i_clk) begin
        r_stride <= vrfm_pkg::VLEN_W'(r_lwb) * vrfm_pkg::VLEN_W'(r_lanes);
    end

    assign w_cfg.vlen_bytes      = r_vlen;
    assign w_cfg.lane_word_bytes = r_lwb;
    assign w_cfg.num_lanes       = r_lanes;
    assign w_cfg.banks_per_lane  = r_banks;
    assign w_cfg.lane_stride     = r_stride;
    assign w_cfg.geo_ok = (r_vlen != '0) && (r_lwb != '0) && (r_lanes != '0) &&
                          (r_banks != '0) && (r_lwb[1:0] == 2'b00) &&
                          (r_lwb <= vrfm_pkg::GEO_W'(vrfm_pkg::MAX_WORD_BYTES)) &&
                          (r_vlen <= vrfm_pkg::VLEN_W'(vrfm_pkg::MAX_VLEN_BYTES)) &&
                          (r_lanes <= vrfm_pkg::GEO_W'(vrfm_pkg::MAX_LANES)) &&
                          (r_banks <= vrfm_pkg::GEO_W'(vrfm_pkg::MAX_BANKS));

    vrfm_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    vrfm_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (w_cfg),
        .i_req_valid (i_req.valid),
        .o_req_ready (w_req_ready),
        .i_req       (i_req.data),
        .o_rsp_valid (w_rsp_valid),
        .i_rsp_ready (o_rsp.ready),
        .o_rsp       (w_rsp),
        .o_div_req   (w_div_req),
        .i_div_rsp   (w_div_rsp)
    );

    assign i_req.ready = w_req_ready;
    assign o_rsp.valid = w_rsp_valid;
    assign o_rsp.data  = w_rsp;

    `VRFM_ASSERT_NEXT(a_busy_after_transfer, i_req.valid && w_req_ready, !w_req_ready, "request taken while the previous one is still in work")
    `VRFM_ASSERT_SAME(a_error_is_last, w_rsp_valid && (w_rsp.status != vrfm_pkg::ST_OK), w_rsp.last_fragment && (w_rsp.fragment_size == 7'd0), "error result is not a lone empty last result")
    `VRFM_ASSERT_SAME(a_fragment_nonempty, w_rsp_valid && (w_rsp.status == vrfm_pkg::ST_OK), w_rsp.fragment_size != 7'd0, "mapped fragment has no bytes")
    `VRFM_ASSERT_SAME(a_div_start_idle, w_div_req.start, !w_div_rsp.busy, "divider started while still busy")
endmodule

// ----- rtl/vrfm_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vrfm_div
// Shared restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module vrfm_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  vrfm_pkg::t_div_req i_req,
    output vrfm_pkg::t_div_rsp o_rsp
);
    localparam int CNT_W = $clog2(vrfm_pkg::DIV_W + 1);

    logic                        r_busy;
    logic                        r_done;
    logic [CNT_W-1:0]            r_cnt;
    logic [vrfm_pkg::DIV_W-1:0]  r_quot;
    logic [vrfm_pkg::DIVR_W-1:0] r_rem;
    logic [vrfm_pkg::DIVR_W-1:0] r_divisor;

    logic [vrfm_pkg::DIVR_W:0]   w_trial;
    logic [vrfm_pkg::DIVR_W:0]   w_diff;
    logic                        w_fits;

    assign w_trial = {r_rem, r_quot[vrfm_pkg::DIV_W-1]};
    assign w_diff  = w_trial - {1'b0, r_divisor};
    assign w_fits  = w_trial >= {1'b0, r_divisor};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(vrfm_pkg::DIV_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // The dividend shifts out of the top of r_quot as quotient bits enter below.
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_quot    <= i_req.dividend;
            r_rem     <= '0;
            r_divisor <= i_req.divisor;
        end else if (r_busy) begin
            r_quot <= {r_quot[vrfm_pkg::DIV_W-2:0], w_fits};
            r_rem  <= w_fits ? w_diff[vrfm_pkg::DIVR_W-1:0]
                             : w_trial[vrfm_pkg::DIVR_W-1:0];
        end
    end

    assign o_rsp.busy = r_busy;
    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_quot;
    assign o_rsp.rem  = r_rem;
endmodule

// ----- rtl/vrfm_seq.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vrfm_seq
// Request sequencer: checks, divider schedule and fragment emission.
// ----------------------------------------------------------------------------
module vrfm_seq (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  vrfm_pkg::t_cfg     i_cfg,
    input  logic               i_req_valid,
    output logic               o_req_ready,
    input  vrfm_pkg::t_req     i_req,
    output logic               o_rsp_valid,
    input  logic               i_rsp_ready,
    output vrfm_pkg::t_rsp     o_rsp,
    output vrfm_pkg::t_div_req o_div_req,
    input  vrfm_pkg::t_div_rsp i_div_rsp
);
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_GEO  = 3'd1;
    localparam logic [2:0] S_GEOW = 3'd2;
    localparam logic [2:0] S_D1   = 3'd3;
    localparam logic [2:0] S_D2   = 3'd4;
    localparam logic [2:0] S_D3   = 3'd5;
    localparam logic [2:0] S_EMIT = 3'd6;
    localparam logic [2:0] S_ERR  = 3'd7;

    logic [2:0]                   r_state;
    logic [2:0]                   r_status;
    logic [4:0]                   r_first;
    logic [5:0]                   r_count;
    logic [15:0]                  r_roff;
    logic [6:0]                   r_remain;
    logic [15:0]                  r_foff;
    logic [vrfm_pkg::BE_W-1:0]    r_be;
    logic [vrfm_pkg::BASE_W-1:0]  r_base;
    logic [vrfm_pkg::DIV_W-1:0]   r_cap;
    logic [vrfm_pkg::DIV_W-1:0]   r_abs;
    logic [5:0]                   r_woff;
    logic [5:0]                   r_lane;
    logic [5:0]                   r_bank;
    logic [15:0]                  r_row;
    logic                         r_rsp_valid;
    vrfm_pkg::t_rsp               r_rsp;

    logic                         w_accept;
    logic                         w_free;
    logic                         w_emit;
    logic [2:0]                   w_chk_status;
    logic [6:0]                   w_avail;
    logic [6:0]                   w_size;
    logic                         w_last;
    logic [vrfm_pkg::BE_W-1:0]    w_mask;
    logic [vrfm_pkg::BE_W-1:0]    w_wen;
    logic [6:0]                   w_lane_inc;
    logic [6:0]                   w_bank_inc;

    assign o_req_ready = (r_state == S_IDLE);
    assign w_accept    = i_req_valid && o_req_ready;
    assign w_free      = !r_rsp_valid || i_rsp_ready;
    assign w_emit      = ((r_state == S_EMIT) || (r_state == S_ERR)) && w_free;

    // Request checks after the geometry has passed, first failure wins.
    always_comb begin
        priority if (r_count == 6'd0 ||
                     ({2'b0, r_first} + {1'b0, r_count}) > 7'(vrfm_pkg::NUM_ARCH_REGS))
            w_chk_status = vrfm_pkg::ST_GRP;
        else if (r_remain == 7'd0 || r_remain > 7'(vrfm_pkg::MAX_RANGE_BYTES))
            w_chk_status = vrfm_pkg::ST_SIZE;
        else if ((vrfm_pkg::DIV_W'(r_roff) + vrfm_pkg::DIV_W'(r_remain)) > r_cap)
            w_chk_status = vrfm_pkg::ST_CAP;
        else
            w_chk_status = vrfm_pkg::ST_OK;
    end

    // Fragment of the current word: up to the word end or the range end.
    assign w_avail    = i_cfg.lane_word_bytes - {1'b0, r_woff};
    assign w_size     = (r_remain < w_avail) ? r_remain : w_avail;
    assign w_last     = (w_size == r_remain);
    assign w_mask     = {vrfm_pkg::BE_W{1'b1}} >> (7'(vrfm_pkg::BE_W) - w_size);
    assign w_wen      = (r_be & w_mask) << r_woff;
    assign w_lane_inc = {1'b0, r_lane} + 7'd1;
    assign w_bank_inc = {1'b0, r_bank} + 7'd1;

    always_comb begin
        o_div_req.start    = 1'b0;
        o_div_req.dividend = r_abs;
        o_div_req.divisor  = vrfm_pkg::DIVR_W'(i_cfg.lane_word_bytes);
        unique case (r_state)
            S_GEO: begin
                o_div_req.start    = i_cfg.geo_ok;
                o_div_req.dividend = vrfm_pkg::DIV_W'(i_cfg.vlen_bytes);
                o_div_req.divisor  = i_cfg.lane_stride;
            end
            S_GEOW: begin
                o_div_req.start = i_div_rsp.done && (i_div_rsp.rem == '0) &&
                                  (w_chk_status == vrfm_pkg::ST_OK);
            end
            S_D1: begin
                o_div_req.start    = i_div_rsp.done;
                o_div_req.dividend = i_div_rsp.quot;
                o_div_req.divisor  = vrfm_pkg::DIVR_W'(i_cfg.num_lanes);
            end
            S_D2: begin
                o_div_req.start    = i_div_rsp.done;
                o_div_req.dividend = i_div_rsp.quot;
                o_div_req.divisor  = vrfm_pkg::DIVR_W'(i_cfg.banks_per_lane);
            end
            S_IDLE, S_D3, S_EMIT, S_ERR: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept)
                        r_state <= S_GEO;
                end
                S_GEO: begin
                    r_state <= i_cfg.geo_ok ? S_GEOW : S_ERR;
                end
                S_GEOW: begin
                    if (i_div_rsp.done) begin
                        if (i_div_rsp.rem != '0 || w_chk_status != vrfm_pkg::ST_OK)
                            r_state <= S_ERR;
                        else
                            r_state <= S_D1;
                    end
                end
                S_D1: begin
                    if (i_div_rsp.done)
                        r_state <= S_D2;
                end
                S_D2: begin
                    if (i_div_rsp.done)
                        r_state <= S_D3;
                end
                S_D3: begin
                    if (i_div_rsp.done)
                        r_state <= S_EMIT;
                end
                S_EMIT: begin
                    if (w_free && w_last)
                        r_state <= S_IDLE;
                end
                S_ERR: begin
                    if (w_free)
                        r_state <= S_IDLE;
                end
            endcase
        end
    end

    // A new result may enter in the same cycle as the waiting one leaves.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rsp_valid <= 1'b0;
        end else if (w_emit) begin
            r_rsp_valid <= 1'b1;
        end else if (i_rsp_ready) begin
            r_rsp_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    r_first  <= i_req.first_reg;
                    r_count  <= i_req.reg_count;
                    r_roff   <= i_req.range_offset;
                    r_remain <= i_req.range_size;
                    r_foff   <= i_req.range_offset;
                    r_be     <= i_req.byte_mask;
                    r_base   <= vrfm_pkg::BASE_W'(i_req.first_reg) *
                                vrfm_pkg::BASE_W'(i_cfg.vlen_bytes);
                    r_cap    <= vrfm_pkg::DIV_W'(i_req.reg_count) *
                                vrfm_pkg::DIV_W'(i_cfg.vlen_bytes);
                end
            end
            S_GEO: begin
                r_abs    <= vrfm_pkg::DIV_W'(r_base) + vrfm_pkg::DIV_W'(r_roff);
                r_status <= vrfm_pkg::ST_GEO;
            end
            S_GEOW: begin
                if (i_div_rsp.done)
                    r_status <= (i_div_rsp.rem != '0) ? vrfm_pkg::ST_GEO : w_chk_status;
            end
            S_D1: begin
                if (i_div_rsp.done)
                    r_woff <= i_div_rsp.rem[5:0];
            end
            S_D2: begin
                if (i_div_rsp.done)
                    r_lane <= i_div_rsp.rem[5:0];
            end
            S_D3: begin
                if (i_div_rsp.done) begin
                    r_bank <= i_div_rsp.rem[5:0];
                    r_row  <= i_div_rsp.quot[15:0];
                end
            end
            S_EMIT: begin
                if (w_free) begin
                    r_rsp.lane_id         <= r_lane;
                    r_rsp.bank_id         <= r_bank;
                    r_rsp.row_index       <= r_row;
                    r_rsp.offset_in_word  <= r_woff;
                    r_rsp.fragment_offset <= r_foff;
                    r_rsp.fragment_size   <= w_size;
                    r_rsp.word_enable     <= w_wen;
                    r_rsp.last_fragment   <= w_last;
                    r_rsp.status          <= vrfm_pkg::ST_OK;
                    r_remain <= r_remain - w_size;
                    r_foff   <= r_foff + 16'(w_size);
                    r_be     <= r_be >> w_size;
                    r_woff   <= 6'd0;
                    // The next word follows in the next lane, wrapping into banks and rows.
                    if (w_lane_inc == i_cfg.num_lanes) begin
                        r_lane <= 6'd0;
                        if (w_bank_inc == i_cfg.banks_per_lane) begin
                            r_bank <= 6'd0;
                            r_row  <= r_row + 16'd1;
                        end else begin
                            r_bank <= w_bank_inc[5:0];
                        end
                    end else begin
                        r_lane <= w_lane_inc[5:0];
                    end
                end
            end
            S_ERR: begin
                if (w_free) begin
                    r_rsp.lane_id         <= 6'd0;
                    r_rsp.bank_id         <= 6'd0;
                    r_rsp.row_index       <= 16'd0;
                    r_rsp.offset_in_word  <= 6'd0;
                    r_rsp.fragment_offset <= 16'd0;
                    r_rsp.fragment_size   <= 7'd0;
                    r_rsp.word_enable     <= '0;
                    r_rsp.last_fragment   <= 1'b1;
                    r_rsp.status          <= r_status;
                end
            end
        endcase
    end

    assign o_rsp_valid = r_rsp_valid;
    assign o_rsp       = r_rsp;
endmodule
